### design/bsm_pkg.sv
// Shared constants, types and sequencer states for the block sort then merge engine.
`timescale 1ns / 1ps

package bsm_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int RCL_W     = 3;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  // Request from the loader that closes a set and starts the sort.
  typedef struct packed {
    logic             go;
    cnt_t             n;
    logic [RCL_W-1:0] rcl;
  } start_req_t;

  // Memory port requests issued by the sequencer.
  typedef struct packed {
    logic  ks_we;
    addr_t ks_waddr;
    key_t  ks_wdata;
    addr_t ks_raddr;
    logic  mb_we;
    addr_t mb_waddr;
    key_t  mb_wdata;
    addr_t mb_raddr;
  } ram_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_S_ARD,
    ST_S_ADAT,
    ST_S_BRD,
    ST_S_BDAT,
    ST_S_SW1,
    ST_S_SW2,
    ST_M_PASS,
    ST_M_INIT,
    ST_M_RDP,
    ST_M_DATP,
    ST_M_RDQ,
    ST_M_DATQ,
    ST_M_STEP,
    ST_M_CPRD,
    ST_M_CPWR,
    ST_E_RD,
    ST_E_DAT,
    ST_E_WAIT
  } sort_state_t;

endpackage

### design/bsm_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module bsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/bsm_sorter.sv
// Sequencer that sorts the stored set with one shared key comparator and streams it out.
`timescale 1ns / 1ps

module bsm_sorter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsm_pkg::start_req_t  start,
  input  bsm_pkg::key_t        ks_rdata,
  input  bsm_pkg::key_t        mb_rdata,
  output bsm_pkg::ram_req_t    req,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bsm_pkg::key_t        out_sorted_key,
  output logic                 out_is_last_res,
  output logic                 out_error
);

  import bsm_pkg::*;

  sort_state_t state_r, state_nxt;

  cnt_t             n_r, n_nxt;
  logic [RCL_W-1:0] rcl_r, rcl_nxt;
  cnt_t             bsize_r, bsize_nxt;
  cnt_t             base_r, base_nxt;
  cnt_t             bend_r, bend_nxt;
  cnt_t             a_r, a_nxt;
  cnt_t             b_r, b_nxt;
  cnt_t             best_r, best_nxt;
  key_t             aval_r, aval_nxt;
  key_t             bestval_r, bestval_nxt;
  cnt_t             run_r, run_nxt;
  cnt_t             lo_r, lo_nxt;
  cnt_t             p_r, p_nxt;
  cnt_t             q_r, q_nxt;
  cnt_t             endl_r, endl_nxt;
  cnt_t             endr_r, endr_nxt;
  cnt_t             k_r, k_nxt;
  cnt_t             c_r, c_nxt;
  key_t             pval_r, pval_nxt;
  key_t             qval_r, qval_nxt;
  logic             ov_r, ov_nxt;
  key_t             okey_r, okey_nxt;
  logic             olast_r, olast_nxt;
  logic             oerr_r, oerr_nxt;

  // The one comparator shared by the selection scan and the merge.
  key_t cmp_x, cmp_y;
  logic cmp_lt;

  cnt_t blocks;
  logic bad_set;
  logic p_done, q_done, take_q;
  cnt_t a_inc, b_inc, p_inc, q_inc, c_inc, base_inc;

  assign cmp_x  = (state_r == ST_S_BDAT) ? ks_rdata  : qval_r;
  assign cmp_y  = (state_r == ST_S_BDAT) ? bestval_r : pval_r;
  assign cmp_lt = cmp_x < cmp_y;

  assign blocks  = cnt_t'(1) << rcl_r;
  assign bad_set = (n_r == '0) || (blocks > n_r) || ((n_r & (blocks - cnt_t'(1))) != '0);

  assign p_done = (p_r == endl_r);
  assign q_done = (q_r == endr_r);
  assign take_q = p_done || (!q_done && cmp_lt);

  assign a_inc    = a_r + cnt_t'(1);
  assign b_inc    = b_r + cnt_t'(1);
  assign p_inc    = p_r + cnt_t'(1);
  assign q_inc    = q_r + cnt_t'(1);
  assign c_inc    = c_r + cnt_t'(1);
  assign base_inc = base_r + bsize_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start.go) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (bad_set) begin
          state_nxt = ST_E_WAIT;
        end else if ((n_r >> rcl_r) < cnt_t'(2)) begin
          state_nxt = ST_M_PASS;
        end else begin
          state_nxt = ST_S_ARD;
        end
      end
      ST_S_ARD:  state_nxt = ST_S_ADAT;
      ST_S_ADAT: state_nxt = ST_S_BRD;
      ST_S_BRD:  state_nxt = ST_S_BDAT;
      ST_S_BDAT: state_nxt = (b_inc == bend_r) ? ST_S_SW1 : ST_S_BRD;
      ST_S_SW1:  state_nxt = ST_S_SW2;
      ST_S_SW2: begin
        if ((a_inc + cnt_t'(1)) != bend_r) begin
          state_nxt = ST_S_ARD;
        end else if (base_inc == n_r) begin
          state_nxt = ST_M_PASS;
        end else begin
          state_nxt = ST_S_ARD;
        end
      end
      ST_M_PASS: state_nxt = (run_r == n_r) ? ST_E_RD : ST_M_INIT;
      ST_M_INIT: state_nxt = ST_M_RDP;
      ST_M_RDP:  state_nxt = ST_M_DATP;
      ST_M_DATP: state_nxt = (k_r == '0) ? ST_M_RDQ : ST_M_STEP;
      ST_M_RDQ:  state_nxt = ST_M_DATQ;
      ST_M_DATQ: state_nxt = ST_M_STEP;
      ST_M_STEP: begin
        if (p_done && q_done) begin
          state_nxt = ST_M_CPRD;
        end else if (take_q) begin
          state_nxt = (q_inc < endr_r) ? ST_M_RDQ : ST_M_STEP;
        end else begin
          state_nxt = (p_inc < endl_r) ? ST_M_RDP : ST_M_STEP;
        end
      end
      ST_M_CPRD: state_nxt = ST_M_CPWR;
      ST_M_CPWR: begin
        if ((lo_r + c_inc) != endr_r) begin
          state_nxt = ST_M_CPRD;
        end else if (endr_r == n_r) begin
          state_nxt = ST_M_PASS;
        end else begin
          state_nxt = ST_M_INIT;
        end
      end
      ST_E_RD:   state_nxt = ST_E_DAT;
      ST_E_DAT:  state_nxt = ST_E_WAIT;
      ST_E_WAIT: begin
        if (!out_stall) begin
          state_nxt = olast_r ? ST_IDLE : ST_E_RD;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates and memory requests.
  always_comb begin
    n_nxt       = n_r;
    rcl_nxt     = rcl_r;
    bsize_nxt   = bsize_r;
    base_nxt    = base_r;
    bend_nxt    = bend_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    best_nxt    = best_r;
    aval_nxt    = aval_r;
    bestval_nxt = bestval_r;
    run_nxt     = run_r;
    lo_nxt      = lo_r;
    p_nxt       = p_r;
    q_nxt       = q_r;
    endl_nxt    = endl_r;
    endr_nxt    = endr_r;
    k_nxt       = k_r;
    c_nxt       = c_r;
    pval_nxt    = pval_r;
    qval_nxt    = qval_r;
    ov_nxt      = ov_r;
    okey_nxt    = okey_r;
    olast_nxt   = olast_r;
    oerr_nxt    = oerr_r;
    req         = '0;

    case (state_r)
      ST_IDLE: begin
        if (start.go) begin
          n_nxt   = start.n;
          rcl_nxt = start.rcl;
        end
      end
      ST_CHECK: begin
        bsize_nxt = n_r >> rcl_r;
        base_nxt  = '0;
        a_nxt     = '0;
        bend_nxt  = n_r >> rcl_r;
        run_nxt   = n_r >> rcl_r;
        if (bad_set) begin
          ov_nxt    = 1'b1;
          okey_nxt  = '0;
          olast_nxt = 1'b1;
          oerr_nxt  = 1'b1;
        end
      end
      ST_S_ARD: begin
        req.ks_raddr = a_r[ADDR_W-1:0];
      end
      ST_S_ADAT: begin
        aval_nxt    = ks_rdata;
        bestval_nxt = ks_rdata;
        best_nxt    = a_r;
        b_nxt       = a_inc;
      end
      ST_S_BRD: begin
        req.ks_raddr = b_r[ADDR_W-1:0];
      end
      ST_S_BDAT: begin
        if (cmp_lt) begin
          best_nxt    = b_r;
          bestval_nxt = ks_rdata;
        end
        b_nxt = b_inc;
      end
      ST_S_SW1: begin
        req.ks_we    = 1'b1;
        req.ks_waddr = best_r[ADDR_W-1:0];
        req.ks_wdata = aval_r;
      end
      ST_S_SW2: begin
        req.ks_we    = 1'b1;
        req.ks_waddr = a_r[ADDR_W-1:0];
        req.ks_wdata = bestval_r;
        if ((a_inc + cnt_t'(1)) != bend_r) begin
          a_nxt = a_inc;
        end else begin
          // Block finished: move on to the next one.
          base_nxt = base_inc;
          a_nxt    = base_inc;
          bend_nxt = base_inc + bsize_r;
        end
      end
      ST_M_PASS: begin
        lo_nxt = '0;
        c_nxt  = '0;
      end
      ST_M_INIT: begin
        p_nxt    = lo_r;
        q_nxt    = lo_r + run_r;
        endl_nxt = lo_r + run_r;
        endr_nxt = lo_r + (run_r << 1);
        k_nxt    = '0;
      end
      ST_M_RDP: begin
        req.ks_raddr = p_r[ADDR_W-1:0];
      end
      ST_M_DATP: begin
        pval_nxt = ks_rdata;
      end
      ST_M_RDQ: begin
        req.ks_raddr = q_r[ADDR_W-1:0];
      end
      ST_M_DATQ: begin
        qval_nxt = ks_rdata;
      end
      ST_M_STEP: begin
        if (p_done && q_done) begin
          c_nxt = '0;
        end else begin
          req.mb_we    = 1'b1;
          req.mb_waddr = k_r[ADDR_W-1:0];
          req.mb_wdata = take_q ? qval_r : pval_r;
          k_nxt        = k_r + cnt_t'(1);
          if (take_q) begin
            q_nxt = q_inc;
          end else begin
            p_nxt = p_inc;
          end
        end
      end
      ST_M_CPRD: begin
        req.mb_raddr = c_r[ADDR_W-1:0];
      end
      ST_M_CPWR: begin
        req.ks_we    = 1'b1;
        req.ks_waddr = lo_r[ADDR_W-1:0] + c_r[ADDR_W-1:0];
        req.ks_wdata = mb_rdata;
        c_nxt        = c_inc;
        if ((lo_r + c_inc) == endr_r) begin
          lo_nxt = endr_r;
          c_nxt  = '0;
          if (endr_r == n_r) begin
            run_nxt = run_r << 1;
          end
        end
      end
      ST_E_RD: begin
        req.ks_raddr = c_r[ADDR_W-1:0];
      end
      ST_E_DAT: begin
        ov_nxt    = 1'b1;
        okey_nxt  = ks_rdata;
        olast_nxt = (c_inc == n_r);
        oerr_nxt  = 1'b0;
      end
      ST_E_WAIT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          c_nxt  = c_inc;
        end
      end
      default: begin
        ov_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    rcl_r     <= rcl_nxt;
    bsize_r   <= bsize_nxt;
    base_r    <= base_nxt;
    bend_r    <= bend_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    best_r    <= best_nxt;
    aval_r    <= aval_nxt;
    bestval_r <= bestval_nxt;
    run_r     <= run_nxt;
    lo_r      <= lo_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    endl_r    <= endl_nxt;
    endr_r    <= endr_nxt;
    k_r       <= k_nxt;
    c_r       <= c_nxt;
    pval_r    <= pval_nxt;
    qval_r    <= qval_nxt;
    okey_r    <= okey_nxt;
    olast_r   <= olast_nxt;
    oerr_r    <= oerr_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = ov_r;
  assign out_sorted_key  = okey_r;
  assign out_is_last_res = olast_r;
  assign out_error       = oerr_r;

endmodule

### design/block_sort_then_merge.sv
// Top level of the block sort then merge engine: key loading, configuration and memories.
`timescale 1ns / 1ps
//
// Usage. Keys arrive as words on the in_ channel (valid/stall), one word per cycle while the
// block is idle. Each key is written into the key store; once 64 keys are held, further keys
// are dropped. A word with in_is_last set closes the set and starts the sort.
// The cfg_ channel (valid/ready) writes run_count_log2 before a set is loaded; the set is cut
// into 2^run_count_log2 equal blocks. Each block is selection sorted in place, then runs are
// merged bottom-up through the merge buffer until one ascending run remains.
// After the closing key in_stall stays high until the last result is taken. Sorting a block
// is bounded by the single read port of the key store, which feeds the one shared comparator.
// Each merge pass merges run pairs into the merge buffer and copies each pair back; emitting
// reads each key from the key store and registers it. Results come out on the out_ channel
// (valid/stall); a stalled result is held unchanged until it is taken.
// A block count that exceeds or does not divide the key count yields a single word with
// out_error and out_is_last_res set and a zero key.
// Reset clears the key count, run_count_log2 and the sequencer; the memories need no clearing
// since only keys written in the current set are ever read.
//

module block_sort_then_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bsm_pkg::KEY_WIDTH-1:0] in_key,
  input  logic                       in_is_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bsm_pkg::KEY_WIDTH-1:0] out_sorted_key,
  output logic                       out_is_last_res,
  output logic                       out_error,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bsm_pkg::RCL_W-1:0]  cfg_data
);

  import bsm_pkg::*;

  cnt_t             count_r, count_nxt;
  logic [RCL_W-1:0] rcl_r;

  logic       busy;
  logic       in_acc;
  logic       room;
  start_req_t start;
  ram_req_t   req;
  key_t       ks_rdata, mb_rdata;

  logic  ks_we;
  addr_t ks_waddr;
  key_t  ks_wdata;

  assign in_stall  = busy;
  assign cfg_ready = !busy;
  assign in_acc    = in_valid && !in_stall;
  assign room      = (count_r < cnt_t'(MAX_KEYS));

  // The closing word hands the final count to the sequencer in the cycle it is accepted.
  assign start.go  = in_acc && in_is_last;
  assign start.n   = count_r + (room ? cnt_t'(1) : cnt_t'(0));
  assign start.rcl = rcl_r;

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      if (in_is_last) begin
        count_nxt = '0;
      end else if (room) begin
        count_nxt = count_r + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rcl_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        rcl_r <= cfg_data;
      end
    end
  end

  // The loader owns the key store write port while the sequencer is idle.
  assign ks_we    = busy ? req.ks_we    : (in_acc && room);
  assign ks_waddr = busy ? req.ks_waddr : count_r[ADDR_W-1:0];
  assign ks_wdata = busy ? req.ks_wdata : in_key;

  bsm_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_KEYS)
  ) u_key_store (
    .clk   (clk),
    .we    (ks_we),
    .waddr (ks_waddr),
    .wdata (ks_wdata),
    .raddr (req.ks_raddr),
    .rdata (ks_rdata)
  );

  bsm_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_KEYS)
  ) u_merge_buffer (
    .clk   (clk),
    .we    (req.mb_we),
    .waddr (req.mb_waddr),
    .wdata (req.mb_wdata),
    .raddr (req.mb_raddr),
    .rdata (mb_rdata)
  );

  bsm_sorter u_sorter (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .ks_rdata        (ks_rdata),
    .mb_rdata        (mb_rdata),
    .req             (req),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sorted_key  (out_sorted_key),
    .out_is_last_res (out_is_last_res),
    .out_error       (out_error)
  );

endmodule
